### rtl/note_square_tone_generator_unit_macros.svh
// Assertion macros for the note square tone generator checker.
// Included by nstg_checker; no other dependencies.
`ifndef NOTE_SQUARE_TONE_GENERATOR_UNIT_MACROS_SVH
`define NOTE_SQUARE_TONE_GENERATOR_UNIT_MACROS_SVH

// checked only outside reset
`define NSTG_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define NSTG_ASSERT_ANY(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nstg_pkg.sv
// Shared types, constants and the note step table of the note square tone generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package nstg_pkg;

	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_NOTE = 2'd1;
	localparam logic [1:0] ACT_FREQ = 2'd2;
	localparam logic [1:0] ACT_STOP = 2'd3;

	localparam logic [3:0] NOTE_MAX     = 4'd11;
	localparam logic [3:0] TOP_OCTAVE   = 4'd8;
	localparam logic [3:0] TABLE_OCTAVE = 4'd8;

	localparam int unsigned QUEUE_DEPTH = 4;

	// step = 6087*f - 29580 + floor((326125012 - 311*f) / 11025)
	localparam logic [12:0] FSTEP_MUL  = 13'd6087;
	localparam logic [8:0]  FERR_MUL   = 9'd311;
	localparam logic [28:0] FBIAS      = 29'd326125012;
	localparam logic [14:0] FOFFSET    = 15'd29580;
	localparam logic [29:0] FRECIP     = 30'd797831567;
	localparam int unsigned FRECIP_SH  = 43;

	// count = floor(floor(duration*441 / 2) / 5)
	localparam logic [8:0]  DUR_MUL    = 9'd441;
	localparam logic [23:0] DIV5_RECIP = 24'd13421773;
	localparam int unsigned DIV5_SH    = 26;

	localparam logic [14:0] MAG_FULL   = 15'd32767;
	localparam logic [15:0] AMP_FULL   = 16'd32768;

	typedef enum logic [1:0] {
		K_TICK,
		K_PLAY,
		K_REJECT,
		K_STOP
	} kind_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [3:0]  note;
		logic [3:0]  octave;
		logic [19:0] frequency_q4;
		logic [15:0] duration_ms;
		logic        timed;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic               playing;
		logic               rejected;
	} out_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] step;
		logic [21:0] count;
		logic        timed;
	} q_entry_t;

	typedef struct packed {
		logic     valid;
		q_entry_t entry;
	} q_push_t;

	function automatic logic [31:0] note_step(input logic [3:0] note);
		logic [31:0] s;
		case (note)
			4'd0:    s = 32'd407681904;
			4'd1:    s = 32'd431923931;
			4'd2:    s = 32'd457607465;
			4'd3:    s = 32'd484818220;
			4'd4:    s = 32'd513647012;
			4'd5:    s = 32'd544190053;
			4'd6:    s = 32'd576549277;
			4'd7:    s = 32'd610832681;
			4'd8:    s = 32'd647154683;
			4'd9:    s = 32'd685636503;
			4'd10:   s = 32'd726406571;
			4'd11:   s = 32'd769600953;
			default: s = 32'd0;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

### rtl/nstg_front.sv
// Front end: accepts items, classifies them and computes phase step and sample count.
// Depends on nstg_pkg; feeds nstg_queue.
`default_nettype none

module nstg_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  nstg_pkg::in_item_t in_data,
	input  logic               room,
	output logic [1:0]         pipe_cnt,
	output nstg_pkg::q_push_t  push
);
	import nstg_pkg::*;

	logic        accept;
	kind_t       kind_c;
	logic [31:0] nstep_c;
	logic [32:0] p6087_c;
	logic [28:0] e_c;
	logic [24:0] d441_c;

	logic        v_s1;
	kind_t       kind_s1;
	logic        is_freq_s1;
	logic        timed_s1;
	logic [31:0] nstep_s1;
	logic [32:0] p6087_s1;
	logic [28:0] e_s1;
	logic [24:0] d441_s1;

	logic [58:0] fprod_c;
	logic [47:0] dprod_c;

	logic        v_s2;
	kind_t       kind_s2;
	logic        is_freq_s2;
	logic        timed_s2;
	logic [31:0] nstep_s2;
	logic [32:0] p6087_s2;
	logic [15:0] quo_s2;
	logic [21:0] cnt_s2;

	logic [32:0] fstep_c;

	assign in_ready = room;
	assign accept   = in_valid & in_ready;
	assign pipe_cnt = {1'b0, v_s1} + {1'b0, v_s2};

	always_comb begin
		case (in_data.action)
			ACT_TICK: kind_c = K_TICK;
			ACT_NOTE: begin
				if (in_data.note > NOTE_MAX || in_data.octave > TOP_OCTAVE) begin
					kind_c = K_REJECT;
				end else begin
					kind_c = K_PLAY;
				end
			end
			ACT_FREQ: kind_c = K_PLAY;
			default:  kind_c = K_STOP;
		endcase
	end

	assign nstep_c = note_step(in_data.note) >> (TABLE_OCTAVE - in_data.octave);
	assign p6087_c = 33'(FSTEP_MUL) * 33'(in_data.frequency_q4);
	assign e_c     = FBIAS - 29'(29'(FERR_MUL) * 29'(in_data.frequency_q4));
	assign d441_c  = 25'(DUR_MUL) * 25'(in_data.duration_ms);

	assign fprod_c = 59'(e_s1) * 59'(FRECIP);
	assign dprod_c = 48'(d441_s1[24:1]) * 48'(DIV5_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1    <= kind_c;
		is_freq_s1 <= (in_data.action == ACT_FREQ);
		timed_s1   <= in_data.timed;
		nstep_s1   <= nstep_c;
		p6087_s1   <= p6087_c;
		e_s1       <= e_c;
		d441_s1    <= d441_c;

		kind_s2    <= kind_s1;
		is_freq_s2 <= is_freq_s1;
		timed_s2   <= timed_s1;
		nstep_s2   <= nstep_s1;
		p6087_s2   <= p6087_s1;
		quo_s2     <= fprod_c[FRECIP_SH +: 16];
		cnt_s2     <= dprod_c[DIV5_SH +: 22];
	end

	assign fstep_c = p6087_s2 + 33'(quo_s2) - 33'(FOFFSET);

	always_comb begin
		push.valid       = v_s2;
		push.entry.kind  = kind_s2;
		push.entry.step  = is_freq_s2 ? fstep_c[31:0] : nstep_s2;
		push.entry.count = cnt_s2;
		push.entry.timed = timed_s2;
	end

endmodule

`default_nettype wire

### rtl/nstg_queue.sv
// Short queue between front and back end, with credit for items still in the front.
// Depends on nstg_pkg.
`default_nettype none

module nstg_queue #(
	parameter int unsigned DEPTH = nstg_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  nstg_pkg::q_push_t  push,
	input  logic [1:0]         pipe_cnt,
	output logic               room,
	output logic               pop_valid,
	input  logic               pop_ready,
	output nstg_pkg::q_entry_t pop_entry
);
	import nstg_pkg::*;

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned OW = $clog2(DEPTH + 4);

	q_entry_t        entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;
	logic [OW-1:0]   occ;

	assign pop       = pop_valid & pop_ready;
	assign pop_valid = (cnt_q != '0);
	assign pop_entry = entries_q[rd_ptr_q];
	assign occ       = OW'(cnt_q) + OW'(pipe_cnt);
	assign room      = (occ < OW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push.valid && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (!push.valid && pop) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			entries_q[wr_ptr_q] <= push.entry;
		end
	end

endmodule

`default_nettype wire

### rtl/nstg_back.sv
// Back end: tone state, amplitude register and the registered result stage.
// Depends on nstg_pkg; fed by nstg_queue.
`default_nettype none

module nstg_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data,
	input  logic                q_valid,
	output logic                q_ready,
	input  nstg_pkg::q_entry_t  q_entry,
	output logic                out_valid,
	input  logic                out_ready,
	output nstg_pkg::out_item_t out_data
);
	import nstg_pkg::*;

	logic [14:0] mag_q;
	logic [31:0] phase_q;
	logic [31:0] step_q;
	logic        sounding_q;
	logic        armed_q;
	logic [21:0] left_q;
	logic        out_valid_q;
	out_item_t   out_data_q;

	logic [31:0] phase_d;
	logic [31:0] step_d;
	logic        snd_d;
	logic        arm_d;
	logic [21:0] left_d;
	logic [21:0] left_dec;
	logic        pos;
	logic [15:0] smag;
	logic [15:0] sneg;
	out_item_t   res;
	logic        pop;
	logic [14:0] mag_wr;

	assign cfg_ready = 1'b1;
	assign q_ready   = !out_valid_q || out_ready;
	assign pop       = q_valid & q_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign pos      = (phase_q != '0) && !phase_q[31];
	assign smag     = {1'b0, mag_q};
	assign sneg     = 16'd0 - smag;
	assign left_dec = left_q - 22'd1;

	always_comb begin
		if (cfg_data == '0) begin
			mag_wr = '0;
		end else if (cfg_data >= AMP_FULL) begin
			mag_wr = MAG_FULL;
		end else begin
			mag_wr = 15'(cfg_data - 16'd1);
		end
	end

	always_comb begin
		phase_d = phase_q;
		step_d  = step_q;
		snd_d   = sounding_q;
		arm_d   = armed_q;
		left_d  = left_q;
		res     = '0;
		case (q_entry.kind)
			K_TICK: begin
				if (sounding_q) begin
					res.sample = pos ? smag : sneg;
					phase_d    = phase_q + step_q;
					if (armed_q) begin
						left_d = left_dec;
						if (left_dec == '0) begin
							snd_d = 1'b0;
							arm_d = 1'b0;
						end
					end
				end
			end
			K_PLAY: begin
				phase_d = '0;
				step_d  = q_entry.step;
				arm_d   = q_entry.timed && (q_entry.count != '0);
				left_d  = arm_d ? q_entry.count : '0;
				snd_d   = !q_entry.timed || (q_entry.count != '0);
			end
			K_REJECT: begin
				res.rejected = 1'b1;
			end
			K_STOP: begin
				snd_d  = 1'b0;
				arm_d  = 1'b0;
				left_d = '0;
			end
			default: begin
				res = '0;
			end
		endcase
		res.playing = snd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q       <= MAG_FULL;
			phase_q     <= '0;
			step_q      <= '0;
			sounding_q  <= 1'b0;
			armed_q     <= 1'b0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mag_q <= mag_wr;
			end
			if (pop) begin
				phase_q    <= phase_d;
				step_q     <= step_d;
				sounding_q <= snd_d;
				armed_q    <= arm_d;
				left_q     <= left_d;
			end
			if (q_ready) begin
				out_valid_q <= q_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_data_q <= res;
		end
	end

endmodule

`default_nettype wire

### rtl/note_square_tone_generator_unit.sv
// Top level of the note square tone generator: front end, queue and back end.
// Depends on nstg_pkg, nstg_front, nstg_queue and nstg_back.
//
//   channel | direction | payload          | handshake
//   --------+-----------+------------------+---------------------
//   in      | input     | in_data  (47 b)  | in_valid / in_ready
//   out     | output    | out_data (18 b)  | out_valid / out_ready
//   cfg     | input     | cfg_data (16 b)  | cfg_valid / cfg_ready
//
// One item per cycle sustained while out_ready is high and the queue has room; each item passes
// two front stages for the step and count arithmetic, the queue and the result register.
// in_ready drops once the queue plus the two front stages hold QDEPTH items.
// cfg_ready is always high; reset sets amplitude to full scale and stops the tone.
// The back end stalls only on out_ready; the front end keeps filling the queue.
`default_nettype none

module note_square_tone_generator_unit #(
	parameter int unsigned QDEPTH = nstg_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nstg_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output nstg_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import nstg_pkg::*;

	q_push_t    push;
	logic [1:0] pipe_cnt;
	logic       room;
	logic       q_valid;
	logic       q_ready;
	q_entry_t   q_entry;

	nstg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.room     (room),
		.pipe_cnt (pipe_cnt),
		.push     (push)
	);

	nstg_queue #(
		.DEPTH (QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pipe_cnt  (pipe_cnt),
		.room      (room),
		.pop_valid (q_valid),
		.pop_ready (q_ready),
		.pop_entry (q_entry)
	);

	nstg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_entry   (q_entry),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

### rtl/nstg_checker.sv
// Port-level checker for the note square tone generator, bound to the top level.
// Depends on nstg_pkg and note_square_tone_generator_unit_macros.svh.
`default_nettype none
`include "note_square_tone_generator_unit_macros.svh"

module nstg_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input nstg_pkg::out_item_t out_data
);
	import nstg_pkg::*;

	`NSTG_ASSERT_ANY(a_no_result_in_reset, !arst_n |=> !out_valid, "result valid after reset")
	`NSTG_ASSERT_RST(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "stalled result changed")
	`NSTG_ASSERT_RST(a_reject_silent, out_valid && out_data.rejected |-> out_data.sample == 16'sd0, "rejected item carries a sample")
	`NSTG_ASSERT_RST(a_sample_range, out_valid |-> out_data.sample != 16'sh8000, "sample outside symmetric range")

endmodule

bind note_square_tone_generator_unit nstg_checker u_nstg_checker (.*);

`default_nettype wire
